### design/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and reset
`define HCB_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define HCB_ASSERT(lbl, prop, msg) \
   `HCB_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

### design/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// shared widths, command codes and control structs of the huffman code builder
// ----------------------------------------------------------------------------
package hcb_pkg;

   localparam int SYM_W           = 8;
   localparam int FREQ_W          = 16;
   localparam int LEN_W           = 5;
   localparam int CODE_W          = 31;
   localparam int DEPTH_W         = 7;
   localparam int MAX_SYMBOLS_DEF = 32;

   // write source of the active list
   typedef enum logic [1:0] {
      LSRC_LOAD  = 2'd0,
      LSRC_CI    = 2'd1,
      LSRC_MERGE = 2'd2,
      LSRC_READ  = 2'd3
   } list_src_type;

   // write source of the walk stack
   typedef enum logic [1:0] {
      SSRC_ROOT  = 2'd0,
      SSRC_RIGHT = 2'd1,
      SSRC_LEFT  = 2'd2
   } stack_src_type;

   typedef struct packed {
      logic          list_we;
      list_src_type  list_src;
      logic          label_we;
      logic          node_we;
      logic          ci_load;
      logic          stack_we;
      stack_src_type stack_src;
      logic          stack_re;
      logic          out_load;
      logic          last_leaf;
   } cmd_type;

   typedef struct packed {
      logic swap;
      logic leaf;
      logic out_free;
   } stat_type;

endpackage

### design/hcb_ifs.sv
// ----------------------------------------------------------------------------
// hcb channel interfaces
// valid/ready channels for symbol loading and code results
// ----------------------------------------------------------------------------
interface hcb_req_if;
   logic                       valid;
   logic                       ready;
   logic [hcb_pkg::SYM_W-1:0]  symbol_id;
   logic [hcb_pkg::FREQ_W-1:0] frequency;
   logic                       last_symbol;

   modport source (output valid, symbol_id, frequency, last_symbol, input ready);
   modport sink   (input valid, symbol_id, frequency, last_symbol, output ready);
endinterface

interface hcb_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [hcb_pkg::SYM_W-1:0]  out_symbol;
   logic [hcb_pkg::LEN_W-1:0]  code_length;
   logic [hcb_pkg::CODE_W-1:0] code_bits;
   logic                       last_code;

   modport source (output valid, out_symbol, code_length, code_bits, last_code,
                   input ready);
   modport sink   (input valid, out_symbol, code_length, code_bits, last_code,
                   output ready);
endinterface

### design/huffman_code_builder_core.sv
// ----------------------------------------------------------------------------
// huffman_code_builder_core
// builds a huffman code over a loaded symbol set and streams one code per leaf
// ----------------------------------------------------------------------------
// Symbols are loaded one transaction per cycle; each is appended as a leaf
// unless MAX_SYMBOLS are already held, in which case it is dropped. The
// transaction with last_symbol set starts the build, during which req is not
// ready. Each merge round runs an exchange sort and then a shift, all through
// the single read and single write port of the active list memory. The
// depth-first walk then pops the stack, reads the node and label and uses the
// entry for each leaf, and pushes both children for each merged node; each
// leaf code leaves through an output register that holds while rsp is stalled.
// Codes are right-aligned with the first branch (left = 1) in the top valid
// bit; a single symbol gets a zero-length code. All memories need no clearing.
// ----------------------------------------------------------------------------
module huffman_code_builder_core #(
   parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   hcb_req_if.sink   req_bus,
   hcb_rsp_if.source rsp_bus
);

   localparam int LW  = $clog2(MAX_SYMBOLS);
   localparam int NW  = $clog2(2*MAX_SYMBOLS-1);
   localparam int CW  = $clog2(MAX_SYMBOLS+1);
   localparam int SAW = $clog2(MAX_SYMBOLS+1);

   // command and status between sequencer and datapath
   hcb_pkg::cmd_type  cmd;
   hcb_pkg::stat_type stat;

   // addresses owned by the sequencer
   logic [LW-1:0]  list_rd_addr;
   logic [LW-1:0]  list_wr_addr;
   logic [NW-1:0]  node_addr;
   logic [NW-1:0]  load_node;
   logic [NW-1:0]  root;
   logic [CW-1:0]  leaves;
   logic [SAW-1:0] stk_rd_addr;
   logic [SAW-1:0] stk_wr_addr;

   // load, sort, merge and walk sequencing
   hcb_ctrl #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_last     (req_bus.last_symbol),
      .req_ready    (req_bus.ready),
      .cmd          (cmd),
      .stat         (stat),
      .list_rd_addr (list_rd_addr),
      .list_wr_addr (list_wr_addr),
      .node_addr    (node_addr),
      .load_node    (load_node),
      .root         (root),
      .leaves       (leaves),
      .stk_rd_addr  (stk_rd_addr),
      .stk_wr_addr  (stk_wr_addr)
   );

   // memories, sort compare, merge adder and result register
   hcb_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .list_rd_addr (list_rd_addr),
      .list_wr_addr (list_wr_addr),
      .node_addr    (node_addr),
      .load_node    (load_node),
      .root         (root),
      .leaves       (leaves),
      .stk_rd_addr  (stk_rd_addr),
      .stk_wr_addr  (stk_wr_addr),
      .symbol_id    (req_bus.symbol_id),
      .frequency    (req_bus.frequency),
      .rsp_ready    (rsp_bus.ready),
      .rsp_valid    (rsp_bus.valid),
      .out_symbol   (rsp_bus.out_symbol),
      .code_length  (rsp_bus.code_length),
      .code_bits    (rsp_bus.code_bits),
      .last_code    (rsp_bus.last_code)
   );

endmodule

### design/hcb_datapath.sv
// ----------------------------------------------------------------------------
// hcb_datapath
// active list, node, label and walk stack memories plus the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcb_datapath #(
   parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  hcb_pkg::cmd_type                        cmd,
   output hcb_pkg::stat_type                       stat,
   input  logic [$clog2(MAX_SYMBOLS)-1:0]          list_rd_addr,
   input  logic [$clog2(MAX_SYMBOLS)-1:0]          list_wr_addr,
   input  logic [$clog2(2*MAX_SYMBOLS-1)-1:0]      node_addr,
   input  logic [$clog2(2*MAX_SYMBOLS-1)-1:0]      load_node,
   input  logic [$clog2(2*MAX_SYMBOLS-1)-1:0]      root,
   input  logic [$clog2(MAX_SYMBOLS+1)-1:0]        leaves,
   input  logic [$clog2(MAX_SYMBOLS+1)-1:0]        stk_rd_addr,
   input  logic [$clog2(MAX_SYMBOLS+1)-1:0]        stk_wr_addr,
   input  logic [hcb_pkg::SYM_W-1:0]               symbol_id,
   input  logic [hcb_pkg::FREQ_W-1:0]              frequency,
   input  logic                                    rsp_ready,
   output logic                                    rsp_valid,
   output logic [hcb_pkg::SYM_W-1:0]               out_symbol,
   output logic [hcb_pkg::LEN_W-1:0]               code_length,
   output logic [hcb_pkg::CODE_W-1:0]              code_bits,
   output logic                                    last_code
);

   localparam int LW    = $clog2(MAX_SYMBOLS);
   localparam int NW    = $clog2(2*MAX_SYMBOLS-1);
   localparam int NODES = 2*MAX_SYMBOLS-1;
   localparam int WW    = hcb_pkg::FREQ_W + $clog2(MAX_SYMBOLS);
   localparam int LEW   = WW + NW;
   localparam int DW    = hcb_pkg::DEPTH_W;
   localparam int CDW   = hcb_pkg::CODE_W;
   localparam int SEW   = NW + DW + CDW;

   logic [LEW-1:0]           list_mem [MAX_SYMBOLS];
   logic [NW-1:0]            left_mem [NODES];
   logic [NW-1:0]            right_mem [NODES];
   logic [hcb_pkg::SYM_W-1:0] label_mem [MAX_SYMBOLS];
   logic [SEW-1:0]           stack_mem [MAX_SYMBOLS+1];

   logic [LEW-1:0]            list_q_ff;
   logic [LEW-1:0]            ci_ff;
   logic [NW-1:0]             left_q_ff;
   logic [NW-1:0]             right_q_ff;
   logic [hcb_pkg::SYM_W-1:0] label_q_ff;
   logic [SEW-1:0]            stk_q_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [hcb_pkg::SYM_W-1:0] out_symbol_ff;
   logic [hcb_pkg::LEN_W-1:0] code_length_ff;
   logic [CDW-1:0]            code_bits_ff;
   logic                      last_code_ff;

   logic [WW-1:0]  ci_w;
   logic [WW-1:0]  q_w;
   logic [LEW-1:0] list_wdata;
   logic [SEW-1:0] stk_wdata;
   logic [NW-1:0]  ent_node;
   logic [DW-1:0]  ent_depth;
   logic [CDW-1:0] ent_code;
   logic [DW-1:0]  child_depth;
   logic [CDW-1:0] child_code;

   assign ci_w      = ci_ff[LEW-1:NW];
   assign q_w       = list_q_ff[LEW-1:NW];
   assign ent_node  = stk_q_ff[SEW-1:DW+CDW];
   assign ent_depth = stk_q_ff[DW+CDW-1:CDW];
   assign ent_code  = stk_q_ff[CDW-1:0];
   assign child_depth = ent_depth + DW'(1);
   assign child_code  = {ent_code[CDW-2:0], 1'b0};

   always_comb begin
      case (cmd.list_src)
         hcb_pkg::LSRC_LOAD:  list_wdata = {WW'(frequency), load_node};
         hcb_pkg::LSRC_CI:    list_wdata = ci_ff;
         hcb_pkg::LSRC_MERGE: list_wdata = {ci_w + q_w, node_addr};
         hcb_pkg::LSRC_READ:  list_wdata = list_q_ff;
         default:             list_wdata = list_q_ff;
      endcase
   end

   always_comb begin
      case (cmd.stack_src)
         hcb_pkg::SSRC_ROOT:  stk_wdata = {root, DW'(0), CDW'(0)};
         hcb_pkg::SSRC_RIGHT: stk_wdata = {right_q_ff, child_depth, child_code};
         hcb_pkg::SSRC_LEFT:  stk_wdata = {left_q_ff, child_depth, child_code | CDW'(1)};
         default:             stk_wdata = {root, DW'(0), CDW'(0)};
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.list_we) begin
         list_mem[list_wr_addr] <= list_wdata;
      end
      list_q_ff <= list_mem[list_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.label_we) begin
         label_mem[list_wr_addr] <= symbol_id;
      end
      label_q_ff <= label_mem[ent_node[LW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.node_we) begin
         left_mem[node_addr]  <= ci_ff[NW-1:0];
         right_mem[node_addr] <= list_q_ff[NW-1:0];
      end
      left_q_ff  <= left_mem[ent_node];
      right_q_ff <= right_mem[ent_node];
   end

   always_ff @(posedge clock) begin
      if (cmd.stack_we) begin
         stack_mem[stk_wr_addr] <= stk_wdata;
      end
      if (cmd.stack_re) begin
         stk_q_ff <= stack_mem[stk_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ci_load) begin
         ci_ff <= list_q_ff;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_symbol_ff  <= label_q_ff;
         code_length_ff <= ent_depth[hcb_pkg::LEN_W-1:0];
         code_bits_ff   <= ent_code;
         last_code_ff   <= cmd.last_leaf;
      end
   end

   assign stat.swap     = ci_w > q_w;
   assign stat.leaf     = ent_node < NW'(leaves);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign out_symbol  = out_symbol_ff;
   assign code_length = code_length_ff;
   assign code_bits   = code_bits_ff;
   assign last_code   = last_code_ff;

   `HCB_ASSERT(a_out_load_free, cmd.out_load |-> (!rsp_valid_ff || rsp_ready), "result overwritten")

endmodule

### design/hcb_ctrl.sv
// ----------------------------------------------------------------------------
// hcb_ctrl
// sequencer for loading, exchange sort, merge, shift and depth-first walk
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcb_ctrl #(
   parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_last,
   output logic                               req_ready,
   output hcb_pkg::cmd_type                   cmd,
   input  hcb_pkg::stat_type                  stat,
   output logic [$clog2(MAX_SYMBOLS)-1:0]     list_rd_addr,
   output logic [$clog2(MAX_SYMBOLS)-1:0]     list_wr_addr,
   output logic [$clog2(2*MAX_SYMBOLS-1)-1:0] node_addr,
   output logic [$clog2(2*MAX_SYMBOLS-1)-1:0] load_node,
   output logic [$clog2(2*MAX_SYMBOLS-1)-1:0] root,
   output logic [$clog2(MAX_SYMBOLS+1)-1:0]   leaves,
   output logic [$clog2(MAX_SYMBOLS+1)-1:0]   stk_rd_addr,
   output logic [$clog2(MAX_SYMBOLS+1)-1:0]   stk_wr_addr
);

   localparam int LW  = $clog2(MAX_SYMBOLS);
   localparam int NW  = $clog2(2*MAX_SYMBOLS-1);
   localparam int CW  = $clog2(MAX_SYMBOLS+1);
   localparam int SAW = $clog2(MAX_SYMBOLS+1);
   localparam int SPW = $clog2(MAX_SYMBOLS+2);

   typedef enum logic [14:0] {
      S_IDLE    = 15'b000000000000001,
      S_SI_RD   = 15'b000000000000010,
      S_SI_CAP  = 15'b000000000000100,
      S_SJ_CMP  = 15'b000000000001000,
      S_SI_WB   = 15'b000000000010000,
      S_MG_RD0  = 15'b000000000100000,
      S_MG_RD1  = 15'b000000001000000,
      S_MG_WR   = 15'b000000010000000,
      S_SH_RD   = 15'b000000100000000,
      S_SH_WR   = 15'b000001000000000,
      S_WK_INIT = 15'b000010000000000,
      S_WK_POP  = 15'b000100000000000,
      S_WK_DEC  = 15'b001000000000000,
      S_WK_USE  = 15'b010000000000000,
      S_WK_PUSH = 15'b100000000000000
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  n_ff, n_in;
   logic [NW-1:0]  next_ff, next_in;
   logic [NW-1:0]  root_ff, root_in;
   logic [LW-1:0]  i_ff, i_in;
   logic [LW-1:0]  j_ff, j_in;
   logic [LW-1:0]  k_ff, k_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [CW-1:0]  cnt_nx;
   logic           has_room;
   logic           can_push;
   logic [SPW-1:0] sp_dec;
   logic [SPW-1:0] sp_inc;

   assign has_room = count_ff < CW'(MAX_SYMBOLS);
   assign cnt_nx   = has_room ? count_ff + CW'(1) : count_ff;
   assign can_push = ((SPW+1)'(sp_ff) + (SPW+1)'(2)) <= (SPW+1)'(MAX_SYMBOLS + 1);
   assign sp_dec   = sp_ff - SPW'(1);
   assign sp_inc   = sp_ff + SPW'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      next_in      = next_ff;
      root_in      = root_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      sp_in        = sp_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      list_rd_addr = '0;
      list_wr_addr = '0;
      stk_rd_addr  = '0;
      stk_wr_addr  = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            list_wr_addr = count_ff[LW-1:0];
            if (req_valid) begin
               if (has_room) begin
                  cmd.list_we  = 1'b1;
                  cmd.list_src = hcb_pkg::LSRC_LOAD;
                  cmd.label_we = 1'b1;
               end
               count_in = cnt_nx;
               if (req_last) begin
                  n_in    = cnt_nx;
                  next_in = NW'(cnt_nx);
                  root_in = '0;
                  i_in    = '0;
                  state_in = (cnt_nx == CW'(1)) ? S_WK_INIT : S_SI_RD;
               end
            end
         end
         S_SI_RD: begin
            list_rd_addr = i_ff;
            j_in         = i_ff + LW'(1);
            state_in     = S_SI_CAP;
         end
         S_SI_CAP: begin
            cmd.ci_load  = 1'b1;
            list_rd_addr = j_ff;
            state_in     = S_SJ_CMP;
         end
         S_SJ_CMP: begin
            list_wr_addr = j_ff;
            if (stat.swap) begin
               cmd.list_we  = 1'b1;
               cmd.list_src = hcb_pkg::LSRC_CI;
               cmd.ci_load  = 1'b1;
            end
            if (CW'(j_ff) + CW'(1) == n_ff) begin
               state_in = S_SI_WB;
            end else begin
               j_in         = j_ff + LW'(1);
               list_rd_addr = j_ff + LW'(1);
            end
         end
         S_SI_WB: begin
            cmd.list_we  = 1'b1;
            cmd.list_src = hcb_pkg::LSRC_CI;
            list_wr_addr = i_ff;
            if (CW'(i_ff) + CW'(2) == n_ff) begin
               state_in = S_MG_RD0;
            end else begin
               i_in     = i_ff + LW'(1);
               state_in = S_SI_RD;
            end
         end
         S_MG_RD0: begin
            list_rd_addr = '0;
            state_in     = S_MG_RD1;
         end
         S_MG_RD1: begin
            cmd.ci_load  = 1'b1;
            list_rd_addr = LW'(1);
            state_in     = S_MG_WR;
         end
         S_MG_WR: begin
            cmd.node_we  = 1'b1;
            cmd.list_we  = 1'b1;
            cmd.list_src = hcb_pkg::LSRC_MERGE;
            list_wr_addr = '0;
            root_in      = next_ff;
            next_in      = next_ff + NW'(1);
            if (n_ff == CW'(2)) begin
               n_in     = CW'(1);
               state_in = S_WK_INIT;
            end else begin
               k_in     = LW'(1);
               state_in = S_SH_RD;
            end
         end
         S_SH_RD: begin
            list_rd_addr = k_ff + LW'(1);
            state_in     = S_SH_WR;
         end
         S_SH_WR: begin
            cmd.list_we  = 1'b1;
            cmd.list_src = hcb_pkg::LSRC_READ;
            list_wr_addr = k_ff;
            if (CW'(k_ff) + CW'(2) == n_ff) begin
               n_in     = n_ff - CW'(1);
               i_in     = '0;
               state_in = S_SI_RD;
            end else begin
               k_in     = k_ff + LW'(1);
               state_in = S_SH_RD;
            end
         end
         S_WK_INIT: begin
            cmd.stack_we  = 1'b1;
            cmd.stack_src = hcb_pkg::SSRC_ROOT;
            stk_wr_addr   = '0;
            sp_in         = SPW'(1);
            state_in      = S_WK_POP;
         end
         S_WK_POP: begin
            cmd.stack_re = 1'b1;
            stk_rd_addr  = sp_dec[SAW-1:0];
            sp_in        = sp_dec;
            state_in     = S_WK_DEC;
         end
         S_WK_DEC: begin
            state_in = S_WK_USE;
         end
         S_WK_USE: begin
            stk_wr_addr = sp_ff[SAW-1:0];
            if (stat.leaf) begin
               if (stat.out_free) begin
                  cmd.out_load  = 1'b1;
                  cmd.last_leaf = (sp_ff == '0);
                  if (sp_ff == '0) begin
                     count_in = '0;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_WK_POP;
                  end
               end
            end else if (can_push) begin
               cmd.stack_we  = 1'b1;
               cmd.stack_src = hcb_pkg::SSRC_RIGHT;
               state_in      = S_WK_PUSH;
            end else if (sp_ff == '0) begin
               count_in = '0;
               state_in = S_IDLE;
            end else begin
               state_in = S_WK_POP;
            end
         end
         S_WK_PUSH: begin
            cmd.stack_we  = 1'b1;
            cmd.stack_src = hcb_pkg::SSRC_LEFT;
            stk_wr_addr   = sp_inc[SAW-1:0];
            sp_in         = sp_ff + SPW'(2);
            state_in      = S_WK_POP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         n_ff     <= '0;
         next_ff  <= '0;
         root_ff  <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         n_ff     <= n_in;
         next_ff  <= next_in;
         root_ff  <= root_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         sp_ff    <= sp_in;
      end
   end

   assign node_addr = next_ff;
   assign load_node = NW'(count_ff);
   assign root      = root_ff;
   assign leaves    = count_ff;

   `HCB_ASSERT(a_count_bound, count_ff <= CW'(MAX_SYMBOLS), "symbol count past capacity")
   `HCB_ASSERT(a_j_in_list, (state_ff == S_SJ_CMP) |-> (CW'(j_ff) < n_ff), "sort index past list")
   `HCB_ASSERT(a_sp_bound, sp_ff <= SPW'(MAX_SYMBOLS + 1), "walk stack overflow")

endmodule

### test/huffman_code_builder_core_scoreboard.sv
// ----------------------------------------------------------------------------
// huffman code scoreboard
// tracks loaded symbols, predicts the code of every leaf and checks results
// ----------------------------------------------------------------------------
package hcb_test_pkg;

   typedef struct packed {
      logic [hcb_pkg::SYM_W-1:0]  sym;
      logic [hcb_pkg::LEN_W-1:0]  len;
      logic [hcb_pkg::CODE_W-1:0] bits;
      logic                       last;
   } leaf_code_type;

   class huffman_scoreboard;
      int unsigned max_symbols;
      int unsigned weight[];
      int unsigned left_child[];
      int unsigned right_child[];
      logic [hcb_pkg::SYM_W-1:0] label[];
      int unsigned pending_list[];
      int unsigned loaded;
      leaf_code_type expected_codes[$];
      int unsigned mismatches;
      int unsigned codes_checked;
      int unsigned sets_built;

      function new(int unsigned max_sym);
         max_symbols = max_sym;
         weight = new[2 * max_sym];
         left_child = new[2 * max_sym];
         right_child = new[2 * max_sym];
         label = new[max_sym];
         pending_list = new[max_sym];
         loaded = 0;
         mismatches = 0;
         codes_checked = 0;
         sets_built = 0;
      endfunction

      // merge rounds: exchange sort, then fold the first two into one node
      function int unsigned build_tree();
         int unsigned n, next_node, t;
         n = loaded;
         next_node = loaded;
         while (n > 1) begin
            for (int unsigned i = 0; i + 1 < n; i++)
               for (int unsigned j = i; j < n; j++)
                  if (weight[pending_list[i]] > weight[pending_list[j]]) begin
                     t = pending_list[i];
                     pending_list[i] = pending_list[j];
                     pending_list[j] = t;
                  end
            weight[next_node] = weight[pending_list[0]] + weight[pending_list[1]];
            left_child[next_node] = pending_list[0];
            right_child[next_node] = pending_list[1];
            pending_list[0] = next_node;
            for (int unsigned i = 1; i + 1 < n; i++)
               pending_list[i] = pending_list[i + 1];
            next_node++;
            n--;
         end
         return pending_list[0];
      endfunction

      // note one accepted symbol transaction
      function void note_symbol(logic [hcb_pkg::SYM_W-1:0] sym,
                                logic [hcb_pkg::FREQ_W-1:0] freq, logic last_sym);
         int unsigned node_q[$], depth_q[$];
         longint unsigned code_q[$];
         int unsigned node, depth;
         longint unsigned code;
         leaf_code_type lc;
         if (loaded < max_symbols) begin
            weight[loaded] = 32'(freq);
            label[loaded] = sym;
            pending_list[loaded] = loaded;
            loaded++;
         end
         if (!last_sym || loaded == 0) return;
         node_q.push_back(build_tree());
         depth_q.push_back(0);
         code_q.push_back(0);
         while (node_q.size() > 0) begin
            node = node_q.pop_back();
            depth = depth_q.pop_back();
            code = code_q.pop_back();
            if (node < loaded) begin
               lc.sym = label[node];
               lc.len = depth[hcb_pkg::LEN_W-1:0];
               lc.bits = code[hcb_pkg::CODE_W-1:0];
               lc.last = (node_q.size() == 0);
               expected_codes.push_back(lc);
            end else if (node_q.size() + 2 <= max_symbols + 1) begin
               node_q.push_back(right_child[node]);
               depth_q.push_back(depth + 1);
               code_q.push_back(code << 1);
               node_q.push_back(left_child[node]);
               depth_q.push_back(depth + 1);
               code_q.push_back((code << 1) | 64'd1);
            end
         end
         loaded = 0;
         sets_built++;
      endfunction

      // compare one accepted code transaction with the oldest prediction
      function void check_code(leaf_code_type got);
         leaf_code_type want;
         codes_checked++;
         if (expected_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected code: sym %0d len %0d bits %h last %0d",
                        got.sym, got.len, got.bits, got.last);
            return;
         end
         want = expected_codes.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("code mismatch: exp sym %0d len %0d bits %h last %0d,",
                        want.sym, want.len, want.bits, want.last,
                        " got sym %0d len %0d bits %h last %0d",
                        got.sym, got.len, got.bits, got.last);
         end
      endfunction
   endclass
endpackage

### test/huffman_code_builder_core_test.sv
// ----------------------------------------------------------------------------
// huffman_code_builder_core_test
// drives symbol sets through the code builder and checks every leaf code
// ----------------------------------------------------------------------------
// Directed sets cover a single symbol, two symbols, equal and extreme
// frequencies, a full set and an overfull one. Random sets follow, mostly
// small, with a few full ones, and random gaps on both channels.
// ----------------------------------------------------------------------------
module huffman_code_builder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SYM     = hcb_pkg::MAX_SYMBOLS_DEF;
   localparam int IDLE_LIMIT  = 200000;

   logic clock;
   logic reset;
   logic stim_done;
   int unsigned idle_cycles = 0;
   int unsigned symbols_sent;

   hcb_req_if req_bus();
   hcb_rsp_if rsp_bus();

   hcb_test_pkg::huffman_scoreboard code_board;

   huffman_code_builder_core #(.MAX_SYMBOLS(MAX_SYM)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      code_board = new(MAX_SYM);
      req_bus.valid = 1'b0;
      req_bus.symbol_id = '0;
      req_bus.frequency = '0;
      req_bus.last_symbol = 1'b0;
      rsp_bus.ready = 1'b0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // send one symbol transaction after a random gap
   task automatic send_symbol(logic [hcb_pkg::SYM_W-1:0] sym,
                              logic [hcb_pkg::FREQ_W-1:0] freq, logic last_sym);
      int unsigned gap;
      gap = $urandom_range(16);
      if ($urandom_range(3) == 0) gap = 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.symbol_id <= sym;
      req_bus.frequency <= freq;
      req_bus.last_symbol <= last_sym;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      code_board.note_symbol(sym, freq, last_sym);
      symbols_sent++;
      @(negedge clock);
   endtask

   // random set of n symbols; freq_max bounds the counts
   task automatic send_set(int unsigned n, int unsigned freq_max);
      for (int unsigned k = 0; k < n; k++)
         send_symbol(8'($urandom_range(255)), 16'($urandom_range(freq_max)),
                     k == n - 1);
   endtask

   // hold off until every predicted code has come back
   task automatic drain_codes();
      req_bus.valid <= 1'b0;
      while (code_board.expected_codes.size() != 0) @(negedge clock);
   endtask

   // stimulus
   initial begin
      stim_done = 1'b0;
      symbols_sent = 0;
      @(negedge reset);
      @(negedge clock);
      // single symbol, zero length code
      send_symbol(8'hff, 16'hffff, 1'b1);
      // two symbols, extremes of the fields
      send_symbol(8'h00, 16'h0000, 1'b0);
      send_symbol(8'hff, 16'hffff, 1'b1);
      // equal weights keep the load order
      send_symbol(8'h55, 16'h00aa, 1'b0);
      send_symbol(8'haa, 16'h00aa, 1'b0);
      send_symbol(8'h33, 16'h5555, 1'b0);
      send_symbol(8'hcc, 16'haaaa, 1'b1);
      drain_codes();
      // full set with skewed counts gives the longest codes
      for (int unsigned k = 0; k < MAX_SYM; k++)
         send_symbol(k[7:0], (k < 16) ? (16'd1 << k) : 16'hffff, k == MAX_SYM - 1);
      // overfull set: extra symbols and the last one are dropped
      for (int unsigned k = 0; k < MAX_SYM + 3; k++)
         send_symbol(8'($urandom_range(255)), 16'($urandom_range(65535)),
                     k == MAX_SYM + 2);
      drain_codes();
      // random sets, mostly small
      while (symbols_sent < 200) begin
         if ($urandom_range(15) == 0)
            send_set(MAX_SYM, 65535);
         else if ($urandom_range(1))
            send_set($urandom_range(1, 8), $urandom_range(1) ? 65535 : 7);
         else
            send_set($urandom_range(9, 16), 65535);
      end
      req_bus.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // result side with random stalls
   initial begin
      int unsigned gap;
      hcb_test_pkg::leaf_code_type got;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got.sym = rsp_bus.out_symbol;
         got.len = rsp_bus.code_length;
         got.bits = rsp_bus.code_bits;
         got.last = rsp_bus.last_code;
         code_board.check_code(got);
         @(negedge clock);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // end of run
   initial begin
      wait (stim_done === 1'b1);
      while (code_board.expected_codes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("built %0d symbol sets from %0d symbols, checked %0d leaf codes",
               code_board.sets_built, symbols_sent, code_board.codes_checked);
      if (code_board.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("watchdog expired with %0d codes outstanding",
               code_board.expected_codes.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/hcb_pkg.sv
design/hcb_ifs.sv
design/hcb_datapath.sv
design/hcb_ctrl.sv
design/huffman_code_builder_core.sv
test/huffman_code_builder_core_scoreboard.sv
test/huffman_code_builder_core_test.sv
